/* design/ic2s_pkg.sv */
// Shared constants, types and the coefficient unpacking function for the 3x3 convolution core.
`default_nettype none

package ic2s_pkg;

    localparam int KERNEL_SIZE       = 3;
    localparam int PIX_W             = 8;
    localparam int COEF_W            = 16;
    localparam int ROW_W             = KERNEL_SIZE * COEF_W;
    localparam int WIDTH_REG_W       = 11;
    localparam int HEIGHT_REG_W      = 12;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = ROW_W;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int RESET_WIDTH       = 1024;
    localparam int RESET_HEIGHT      = 1024;
    localparam int MIN_DIM           = 3;
    localparam int BORDER            = KERNEL_SIZE - 1;
    localparam int PROD_W            = PIX_W + 1 + COEF_W;
    localparam int ROW_SUM_W         = PROD_W + 2;
    localparam int SUM_W             = ROW_SUM_W + 2;
    localparam int OUT_W             = 16;
    localparam int SUM_SHIFT         = 6;
    localparam int OUT_MAX           = 32767;
    localparam int OUT_MIN           = -32768;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_TOP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_MID    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_BOT    = 3'd4;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [ROW_W-1:0]         coef_row_t;
    typedef pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_t;
    typedef coef_row_t [KERNEL_SIZE-1:0] coef_bank_t;

    typedef struct packed {
        logic valid;
        logic last;
    } item_t;

    function automatic coef_t coef_at(input coef_row_t row, input int unsigned col);
        return coef_t'(row[col*COEF_W +: COEF_W]);
    endfunction

endpackage

`default_nettype wire

/* design/ic2s_line_buf.sv */
// Line buffer memory holding the two previous rows, one read and one write per cycle.
`default_nettype none

module ic2s_line_buf #(
    parameter int MAX_WIDTH = ic2s_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    output ic2s_pkg::pix_t                rd_top,
    output ic2s_pkg::pix_t                rd_mid,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    input  ic2s_pkg::pix_t                wr_top,
    input  ic2s_pkg::pix_t                wr_mid
);
    import ic2s_pkg::*;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_top, wr_mid};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_top = rd_data_reg[2*PIX_W-1:PIX_W];
    assign rd_mid = rd_data_reg[PIX_W-1:0];

endmodule

`default_nettype wire

/* design/ic2s_mac.sv */
// Multiply, row sum, final sum, shift and saturate pipeline with its own output register.
`default_nettype none

module ic2s_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ic2s_pkg::item_t                     item,
    input  ic2s_pkg::win_t                      win,
    input  ic2s_pkg::coef_bank_t                coefs,
    output logic                                item_ready,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ic2s_pkg::OUT_W-1:0]   filtered_value,
    output logic                                last_of_frame
);
    import ic2s_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

    logic signed [PROD_W-1:0]    prod_reg  [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0]    prod_next [KERNEL_SIZE][KERNEL_SIZE];
    logic signed [ROW_SUM_W-1:0] rsum_reg  [KERNEL_SIZE];
    logic signed [ROW_SUM_W-1:0] rsum_next [KERNEL_SIZE];
    logic signed [SUM_W-1:0]     total;
    logic signed [SUM_W-1:0]     shifted;
    logic signed [OUT_W-1:0]     sat_next;
    logic signed [OUT_W-1:0]     out_val_reg;

    logic p_valid_reg, p_last_reg;
    logic r_valid_reg, r_last_reg;
    logic o_valid_reg, o_last_reg;
    logic p_free, r_free, o_free;

    assign o_free     = !o_valid_reg || !out_stall;
    assign r_free     = !r_valid_reg || o_free;
    assign p_free     = !p_valid_reg || r_free;
    assign item_ready = p_free;

    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                prod_next[r][k] = PROD_W'($signed({1'b0, win[r][k]})
                                          * coef_at(coefs[r], k));
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            rsum_next[r] = '0;
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                rsum_next[r] = rsum_next[r] + ROW_SUM_W'(prod_reg[r][k]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            total = total + SUM_W'(rsum_reg[r]);
        end
        shifted = total >>> SUM_SHIFT;
        if (shifted > SAT_HI)
        begin
            sat_next = OUT_W'(SAT_HI);
        end
        else if (shifted < SAT_LO)
        begin
            sat_next = OUT_W'(SAT_LO);
        end
        else
        begin
            sat_next = shifted[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
            begin
                p_valid_reg <= item.valid;
            end
            if (r_free)
            begin
                r_valid_reg <= p_valid_reg;
            end
            if (o_free)
            begin
                o_valid_reg <= r_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free && item.valid)
        begin
            prod_reg   <= prod_next;
            p_last_reg <= item.last;
        end
        if (r_free && p_valid_reg)
        begin
            rsum_reg   <= rsum_next;
            r_last_reg <= p_last_reg;
        end
        if (o_free && r_valid_reg)
        begin
            out_val_reg <= sat_next;
            o_last_reg  <= r_last_reg;
        end
    end

    assign out_valid      = o_valid_reg;
    assign filtered_value = out_val_reg;
    assign last_of_frame  = o_last_reg;

endmodule

`default_nettype wire

/* design/image_conv2d_sat_core.sv */
// Top level of the 3x3 saturating convolution core over a raster pixel stream.
`default_nettype none

// Takes one pixel per clock in raster order and returns one filtered value for every 3x3
// window that lies wholly inside the image, with last_of_frame set on the final value of
// the frame; the first two rows and the first two columns of each row give no output.
// When nothing stalls, a pixel's value reaches the output through registered steps in
// order: the line buffer is read at the transfer, then come the window shift, the nine
// products, the row sums, and the final sum with shift and saturation. The line buffer is
// one memory with a read port and a write port, so a new pixel is taken every cycle; the
// input stalls only when every stage holds an item and the output is stalled.
// Configuration writes are taken at any time (cfg_ready is always high) but must only be
// made while no pixel is in flight.
module image_conv2d_sat_core #(
    parameter int MAX_WIDTH = ic2s_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ic2s_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ic2s_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ic2s_pkg::PIX_W-1:0]           pixel_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ic2s_pkg::OUT_W-1:0]    filtered_value,
    output logic                                 last_of_frame
);
    import ic2s_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WX_W  = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    coef_bank_t              coef_reg;

    logic [COL_W-1:0]        col_reg, col_next;
    logic [HEIGHT_REG_W-1:0] row_reg, row_next;
    logic [WX_W-1:0]         width_x;
    logic [WX_W-1:0]         eff_width;
    logic [COL_W-1:0]        w_last;
    logic [HEIGHT_REG_W-1:0] h_last;
    logic [COL_W-1:0]        idx;
    logic                    end_of_row, end_of_frame, produce;

    logic                    in_fire;
    logic                    s1_valid_reg;
    pix_t                    s1_pix_reg;
    logic [COL_W-1:0]        s1_idx_reg;
    logic                    s1_produce_reg, s1_last_reg;
    logic                    s1_adv;

    pix_t                    lb_top, lb_mid;

    win_t                    win_reg, win_next;
    logic                    s2_valid_reg, s2_last_reg;
    logic                    s2_free;
    item_t                   mac_item;
    logic                    mac_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(RESET_WIDTH);
            height_reg <= HEIGHT_REG_W'(RESET_HEIGHT);
            coef_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg   <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_data[HEIGHT_REG_W-1:0];
                REG_COEFF_TOP:    coef_reg[0] <= cfg_data[ROW_W-1:0];
                REG_COEFF_MID:    coef_reg[1] <= cfg_data[ROW_W-1:0];
                REG_COEFF_BOT:    coef_reg[2] <= cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_x = WX_W'(width_reg);
        if (width_x < WX_W'(MIN_DIM))
        begin
            eff_width = WX_W'(MIN_DIM);
        end
        else if (width_x > WX_W'(MAX_WIDTH))
        begin
            eff_width = WX_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_x;
        end
        w_last = COL_W'(eff_width - WX_W'(1));

        if (height_reg < HEIGHT_REG_W'(MIN_DIM))
        begin
            h_last = HEIGHT_REG_W'(MIN_DIM - 1);
        end
        else
        begin
            h_last = height_reg - HEIGHT_REG_W'(1);
        end

        end_of_row   = (col_reg >= w_last);
        end_of_frame = end_of_row && (row_reg >= h_last);
        produce      = (row_reg >= HEIGHT_REG_W'(BORDER)) && (col_reg >= COL_W'(BORDER));
        idx          = end_of_row ? w_last : col_reg;

        if (end_of_row)
        begin
            col_next = '0;
            row_next = end_of_frame ? '0 : row_reg + HEIGHT_REG_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    assign s2_free  = !s2_valid_reg || mac_ready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                win_reg      <= win_next;
                s2_valid_reg <= s1_produce_reg;
            end
            else if (s2_valid_reg && mac_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg     <= pixel_value;
            s1_idx_reg     <= idx;
            s1_produce_reg <= produce;
            s1_last_reg    <= end_of_frame;
        end
        if (s1_adv)
        begin
            s2_last_reg <= s1_last_reg;
        end
    end

    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            for (int k = 0; k < KERNEL_SIZE - 1; k++)
            begin
                win_next[r][k] = win_reg[r][k+1];
            end
        end
        win_next[0][KERNEL_SIZE-1] = lb_top;
        win_next[1][KERNEL_SIZE-1] = lb_mid;
        win_next[2][KERNEL_SIZE-1] = s1_pix_reg;
    end

    ic2s_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (idx),
        .rd_top  (lb_top),
        .rd_mid  (lb_mid),
        .wr_en   (s1_adv),
        .wr_addr (s1_idx_reg),
        .wr_top  (lb_mid),
        .wr_mid  (s1_pix_reg)
    );

    assign mac_item.valid = s2_valid_reg;
    assign mac_item.last  = s2_last_reg;

    ic2s_mac u_mac (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (mac_item),
        .win            (win_reg),
        .coefs          (coef_reg),
        .item_ready     (mac_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_value (filtered_value),
        .last_of_frame  (last_of_frame)
    );

endmodule

`default_nettype wire

/* design/ic2s_checker.sv */
// Port-level checker for the convolution core and the bind that attaches it.
`default_nettype none

module ic2s_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [ic2s_pkg::OUT_W-1:0]    filtered_value,
    input  logic                                 last_of_frame
);
    import ic2s_pkg::*;

    // A result that is held back keeps its value until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered_value)
                                   && $stable(last_of_frame))
        else $error("output changed while stalled");

    // The input side only stalls when the whole pipeline is backed up from the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // A pixel offered while no result is on offer is taken at once.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_valid |-> !in_stall)
        else $error("input stalled while output was empty");

endmodule

bind image_conv2d_sat_core ic2s_checker u_ic2s_checker (.*);

`default_nettype wire
